// ===== sv/bth_pkg.sv =====
// ----------------------------------------------------------------------------
// Boundary tag heap allocator package
// Shared field types, request types between the sequencer and the word
// access unit, layout constants and tag helper functions.
// ----------------------------------------------------------------------------
package bth_pkg;

    // Default heap store depth in bytes.
    localparam int HEAP_BYTES_DEF = 65536;

    // Heap layout constants (byte offsets and sizes).
    localparam logic [16:0] TAG_BYTES   = 17'd4;
    localparam logic [16:0] LIST_HEAD   = 17'd4;
    localparam logic [16:0] FIRST_BLOCK = 17'd8;
    localparam logic [16:0] LINK_SLOT   = 17'd12;
    localparam logic [16:0] MIN_BLOCK   = 17'd12;
    localparam logic [16:0] SPLIT_SLACK = 17'd12;
    localparam logic [16:0] SIZE_FLOOR  = 17'd32;
    localparam int          SIZE_CEIL   = 65536;

    // Operation codes.
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FAIL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [16:0] request_bytes;
        logic [15:0] payload_offset;
    } t_in;

    typedef struct packed {
        logic [15:0] result_offset;
        logic [1:0]  status;
    } t_out;

    // Word access request from the sequencer.
    typedef struct packed {
        logic        go;
        logic        we;
        logic [16:0] addr;
        logic [31:0] wdata;
    } t_word_req;

    // Word access completion back to the sequencer.
    typedef struct packed {
        logic        done;
        logic [31:0] rdata;
    } t_word_rsp;

    // Byte access to the heap store.
    typedef struct packed {
        logic        we;
        logic [16:0] addr;
        logic [7:0]  wdata;
    } t_byte_req;

    // A negative tag marks an allocated block.
    function automatic logic f_used(input logic [31:0] tag);
        return tag[31];
    endfunction

    // Block size held in a tag.
    function automatic logic [16:0] f_mag(input logic [31:0] tag);
        logic [31:0] neg;
        neg = 32'd0 - tag;
        return tag[31] ? neg[16:0] : tag[16:0];
    endfunction

    // Tag word for a block of the given size.
    function automatic logic [31:0] f_tag(input logic [16:0] size, input logic used);
        logic [31:0] pos;
        pos = {15'd0, size};
        return used ? (32'd0 - pos) : pos;
    endfunction

    function automatic t_word_req f_rd(input logic [16:0] addr);
        t_word_req r;
        r.go    = 1'b1;
        r.we    = 1'b0;
        r.addr  = addr;
        r.wdata = 32'd0;
        return r;
    endfunction

    function automatic t_word_req f_wr(input logic [16:0] addr, input logic [31:0] data);
        t_word_req r;
        r.go    = 1'b1;
        r.we    = 1'b1;
        r.addr  = addr;
        r.wdata = data;
        return r;
    endfunction

endpackage

// ===== sv/bth_mem.sv =====
// ----------------------------------------------------------------------------
// Heap byte store
// Single port byte memory with registered read data.
// ----------------------------------------------------------------------------
module bth_mem
    import bth_pkg::*;
#(
    parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
    input  logic      i_clk,
    input  t_byte_req i_breq,
    output logic [7:0] o_q
);

    localparam int AW = $clog2(HEAP_BYTES);

    logic [7:0]    r_mem [HEAP_BYTES];
    logic [AW-1:0] idx;

    assign idx = AW'(i_breq.addr);

    // A read each cycle, and a write as well when the strobe is high.
    always_ff @(posedge i_clk) begin
        if (i_breq.we) begin
            r_mem[idx] <= i_breq.wdata;
        end
        o_q <= r_mem[idx];
    end

endmodule

// ===== sv/bth_word.sv =====
// ----------------------------------------------------------------------------
// Word access unit
// Reads or writes one little-endian 32-bit word at any byte offset, one byte
// per cycle, and signals completion once all four bytes are through.
// ----------------------------------------------------------------------------
module bth_word
    import bth_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_word_req i_req,
    output t_word_rsp o_rsp,
    output t_byte_req o_breq,
    input  logic [7:0] i_q
);

    logic        r_busy;
    logic [2:0]  r_k;
    logic        r_we;
    logic [16:0] r_addr;
    logic [31:0] r_wdata;
    logic [23:0] r_data;
    logic        last;

    assign last = r_busy && (r_k == 3'd4);

    // Byte address and write strobe for the current phase.
    always_comb begin
        o_breq.addr  = r_addr + {14'd0, r_k};
        o_breq.we    = r_busy && r_we && !last;
        o_breq.wdata = r_wdata[7:0];
        unique case (r_k[1:0])
            2'd0: o_breq.wdata = r_wdata[7:0];
            2'd1: o_breq.wdata = r_wdata[15:8];
            2'd2: o_breq.wdata = r_wdata[23:16];
            2'd3: o_breq.wdata = r_wdata[31:24];
        endcase
    end

    assign o_rsp.done  = last;
    assign o_rsp.rdata = {i_q, r_data};

    // Control: phase counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= 3'd0;
        end else if (!r_busy) begin
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_k    <= 3'd0;
            end
        end else if (last) begin
            r_busy <= 1'b0;
        end else begin
            r_k <= r_k + 3'd1;
        end
    end

    // Payload: request capture and read byte assembly.
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_req.go) begin
            r_we    <= i_req.we;
            r_addr  <= i_req.addr;
            r_wdata <= i_req.wdata;
        end
        if (r_busy && !r_we) begin
            unique case (r_k)
                3'd1: r_data[7:0]   <= i_q;
                3'd2: r_data[15:8]  <= i_q;
                3'd3: r_data[23:16] <= i_q;
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/bth_ctrl.sv =====
// ----------------------------------------------------------------------------
// Allocator sequencer
// Walks the free list and block chain and runs the tag update program, one
// word access at a time through the shared word access unit.
// ----------------------------------------------------------------------------
module bth_ctrl
    import bth_pkg::*;
#(
    parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in         i_req,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_data,
    output t_word_req   o_wreq,
    input  t_word_rsp   i_wrsp,
    output logic        o_done,
    output t_out        o_rsp
);

    localparam int          CAP_INT = (HEAP_BYTES < SIZE_CEIL) ? HEAP_BYTES : SIZE_CEIL;
    localparam logic [16:0] CAP     = 17'(CAP_INT);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_FMT      = 5'd1;
    localparam logic [4:0] S_WAIT     = 5'd2;
    localparam logic [4:0] S_WR       = 5'd3;
    localparam logic [4:0] S_FIN      = 5'd4;
    localparam logic [4:0] S_A_CUR    = 5'd5;
    localparam logic [4:0] S_A_TAG    = 5'd6;
    localparam logic [4:0] S_A_NXT    = 5'd7;
    localparam logic [4:0] S_C_CHK    = 5'd8;
    localparam logic [4:0] S_C_WALK   = 5'd9;
    localparam logic [4:0] S_C_STEP   = 5'd10;
    localparam logic [4:0] S_C_TAG    = 5'd11;
    localparam logic [4:0] S_F_PREV   = 5'd12;
    localparam logic [4:0] S_F_GOTP   = 5'd13;
    localparam logic [4:0] S_F_NEXT   = 5'd14;
    localparam logic [4:0] S_F_GOTN   = 5'd15;
    localparam logic [4:0] S_F_DEC    = 5'd16;
    localparam logic [4:0] S_F_GOTNX  = 5'd17;
    localparam logic [4:0] S_L_GOT    = 5'd18;
    localparam logic [4:0] S_F_LINKED = 5'd19;
    localparam logic [4:0] S_F_HEAD   = 5'd20;

    localparam logic [2:0] SLOT_LAST = 3'd6;

    // Control registers.
    logic [4:0]  r_state, n_state;
    logic [4:0]  r_ret, n_ret;
    logic [4:0]  r_after, n_after;
    logic [2:0]  r_slot, n_slot;
    logic [16:0] r_hs, n_hs;

    // Operation and walk registers.
    logic [31:0] r_rd, n_rd;
    logic [1:0]  r_op, n_op;
    logic [15:0] r_off, n_off;
    logic [16:0] r_link, n_link;
    logic [31:0] r_cur, n_cur;
    logic [17:0] r_need, n_need;
    logic [16:0] r_fsz, n_fsz;
    logic [31:0] r_nxt, n_nxt;
    logic [16:0] r_b, n_b;
    logic [16:0] r_s, n_s;
    logic [16:0] r_nb, n_nb;
    logic [16:0] r_psz, n_psz;
    logic [16:0] r_nsz, n_nsz;
    logic        r_pfree, n_pfree;
    logic        r_nfree, n_nfree;
    logic [17:0] r_p, n_p;
    logic [15:0] r_res, n_res;
    logic [1:0]  r_st, n_st;

    // Tag update program: an optional link write, a first block (used or free),
    // an optional free block, and two optional word writes.
    logic        r_pen, n_pen;
    logic [16:0] r_pa, n_pa;
    logic [31:0] r_pd, n_pd;
    logic [16:0] r_ba, n_ba;
    logic [16:0] r_sa, n_sa;
    logic        r_ua, n_ua;
    logic        r_ben, n_ben;
    logic [16:0] r_bb, n_bb;
    logic [16:0] r_sb, n_sb;
    logic        r_qen, n_qen;
    logic [16:0] r_qa, n_qa;
    logic [31:0] r_qd, n_qd;
    logic        r_ren, n_ren;
    logic [16:0] r_ra, n_ra;
    logic [31:0] r_rdw, n_rdw;

    // Scratch values.
    logic [17:0] req_need;
    logic [16:0] cfg_size;
    logic [16:0] rd_mag;
    logic [16:0] rem;
    logic [16:0] rb;
    logic        slot_en;
    logic [16:0] slot_a;
    logic [31:0] slot_d;

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_FIN);
    assign o_rsp.result_offset = r_res;
    assign o_rsp.status        = r_st;

    assign req_need = {1'b0, i_req.request_bytes} + 18'd8;
    assign rd_mag   = f_mag(r_rd);
    assign rem      = r_fsz - r_need[16:0];
    assign rb       = r_cur[16:0] + r_need[16:0];

    // Configured heap size held within its legal range.
    always_comb begin
        if (i_cfg_data < SIZE_FLOOR) begin
            cfg_size = SIZE_FLOOR;
        end else if (i_cfg_data > CAP) begin
            cfg_size = CAP;
        end else begin
            cfg_size = i_cfg_data;
        end
    end

    // Address and data of the current program slot.
    always_comb begin
        slot_en = 1'b0;
        slot_a  = r_pa;
        slot_d  = r_pd;
        unique case (r_slot)
            3'd0: begin
                slot_en = r_pen && (r_pa != 17'd0);
            end
            3'd1: begin
                slot_en = 1'b1;
                slot_a  = r_ba;
                slot_d  = f_tag(r_sa, r_ua);
            end
            3'd2: begin
                slot_en = 1'b1;
                slot_a  = r_ba + r_sa - TAG_BYTES;
                slot_d  = f_tag(r_sa, r_ua);
            end
            3'd3: begin
                slot_en = r_ben;
                slot_a  = r_bb;
                slot_d  = f_tag(r_sb, 1'b0);
            end
            3'd4: begin
                slot_en = r_ben;
                slot_a  = r_bb + r_sb - TAG_BYTES;
                slot_d  = f_tag(r_sb, 1'b0);
            end
            3'd5: begin
                slot_en = r_qen;
                slot_a  = r_qa;
                slot_d  = r_qd;
            end
            3'd6: begin
                slot_en = r_ren;
                slot_a  = r_ra;
                slot_d  = r_rdw;
            end
            default: ;
        endcase
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;  n_ret   = r_ret;   n_after = r_after; n_slot = r_slot;
        n_hs    = r_hs;     n_rd    = r_rd;    n_op    = r_op;    n_off  = r_off;
        n_link  = r_link;   n_cur   = r_cur;   n_need  = r_need;  n_fsz  = r_fsz;
        n_nxt   = r_nxt;    n_b     = r_b;     n_s     = r_s;     n_nb   = r_nb;
        n_psz   = r_psz;    n_nsz   = r_nsz;   n_pfree = r_pfree; n_nfree = r_nfree;
        n_p     = r_p;      n_res   = r_res;   n_st    = r_st;
        n_pen   = r_pen;    n_pa    = r_pa;    n_pd    = r_pd;
        n_ba    = r_ba;     n_sa    = r_sa;    n_ua    = r_ua;
        n_ben   = r_ben;    n_bb    = r_bb;    n_sb    = r_sb;
        n_qen   = r_qen;    n_qa    = r_qa;    n_qd    = r_qd;
        n_ren   = r_ren;    n_ra    = r_ra;    n_rdw   = r_rdw;
        o_wreq  = '0;

        unique case (r_state)
            // Wait for a request or a configuration write.
            S_IDLE: begin
                n_pen  = 1'b0;
                n_ben  = 1'b0;
                n_qen  = 1'b0;
                n_ren  = 1'b0;
                n_slot = 3'd0;
                n_res  = 16'd0;
                n_st   = ST_OK;
                n_after = S_FIN;
                if (i_cfg_we) begin
                    n_hs    = cfg_size;
                    n_state = S_FMT;
                end else if (start) begin
                    n_op  = i_req.operation;
                    n_off = i_req.payload_offset;
                    unique case (i_req.operation)
                        OP_ALLOC: begin
                            n_need = (req_need < {1'b0, MIN_BLOCK}) ?
                                     {1'b0, MIN_BLOCK} : req_need;
                            n_link = LIST_HEAD;
                            if (i_req.request_bytes == 17'd0) begin
                                n_st    = ST_FAIL;
                                n_state = S_FIN;
                            end else begin
                                o_wreq  = f_rd(LIST_HEAD);
                                n_ret   = S_A_CUR;
                                n_state = S_WAIT;
                            end
                        end
                        OP_FREE, OP_CHECK: begin
                            n_state = S_C_CHK;
                        end
                        default: begin
                            n_st    = ST_BAD;
                            n_state = S_FIN;
                        end
                    endcase
                end
            end

            // Format the heap as one free block at the list head.
            S_FMT: begin
                n_pen   = 1'b0;
                n_ben   = 1'b0;
                n_ba    = FIRST_BLOCK;
                n_sa    = r_hs - FIRST_BLOCK;
                n_ua    = 1'b0;
                n_qen   = 1'b1;
                n_qa    = LINK_SLOT;
                n_qd    = 32'd0;
                n_ren   = 1'b1;
                n_ra    = LIST_HEAD;
                n_rdw   = {15'd0, FIRST_BLOCK};
                n_slot  = 3'd0;
                n_after = S_IDLE;
                n_state = S_WR;
            end

            // A word access is in flight.
            S_WAIT: begin
                if (i_wrsp.done) begin
                    n_rd    = i_wrsp.rdata;
                    n_state = r_ret;
                end
            end

            // Run the tag update program slot by slot.
            S_WR: begin
                n_slot = r_slot + 3'd1;
                if (slot_en) begin
                    o_wreq  = f_wr(slot_a, slot_d);
                    n_ret   = (r_slot == SLOT_LAST) ? r_after : S_WR;
                    n_state = S_WAIT;
                end else if (r_slot == SLOT_LAST) begin
                    n_state = r_after;
                end
            end

            S_FIN: begin
                n_state = S_IDLE;
            end

            // First fit: follow the link just read.
            S_A_CUR: begin
                n_cur = r_rd;
                if (r_rd == 32'd0) begin
                    n_st    = ST_FAIL;
                    n_state = S_FIN;
                end else begin
                    o_wreq  = f_rd(r_rd[16:0]);
                    n_ret   = S_A_TAG;
                    n_state = S_WAIT;
                end
            end

            // First fit: compare the block size with the need.
            S_A_TAG: begin
                n_fsz = rd_mag;
                if ({1'b0, rd_mag} >= r_need) begin
                    o_wreq  = f_rd(r_cur[16:0] + TAG_BYTES);
                    n_ret   = S_A_NXT;
                    n_state = S_WAIT;
                end else begin
                    n_link  = r_cur[16:0] + TAG_BYTES;
                    o_wreq  = f_rd(r_cur[16:0] + TAG_BYTES);
                    n_ret   = S_A_CUR;
                    n_state = S_WAIT;
                end
            end

            // Fit found: split it or hand out the whole block.
            S_A_NXT: begin
                n_ba  = r_cur[16:0];
                n_ua  = 1'b1;
                n_res = 16'(r_cur[16:0] + TAG_BYTES);
                if (rem > SPLIT_SLACK) begin
                    n_sa  = r_need[16:0];
                    n_ben = 1'b1;
                    n_bb  = rb;
                    n_sb  = rem;
                    n_qen = 1'b1;
                    n_qa  = rb + TAG_BYTES;
                    n_qd  = r_rd;
                    n_ren = 1'b1;
                    n_ra  = r_link;
                    n_rdw = {15'd0, rb};
                end else begin
                    n_sa  = r_fsz;
                    n_qen = 1'b1;
                    n_qa  = r_link;
                    n_qd  = r_rd;
                end
                n_state = S_WR;
            end

            // Offset range check.
            S_C_CHK: begin
                if ({1'b0, r_off} < (FIRST_BLOCK + TAG_BYTES) || {1'b0, r_off} >= r_hs) begin
                    n_st    = ST_BAD;
                    n_state = S_FIN;
                end else begin
                    n_b     = {1'b0, r_off} - TAG_BYTES;
                    n_p     = {1'b0, FIRST_BLOCK};
                    n_state = S_C_WALK;
                end
            end

            // Walk the block chain looking for a block at the offset.
            S_C_WALK: begin
                if (r_p >= {1'b0, r_hs}) begin
                    n_st    = ST_FAIL;
                    n_state = S_FIN;
                end else if (r_p[16:0] == r_b) begin
                    o_wreq  = f_rd(r_b);
                    n_ret   = S_C_TAG;
                    n_state = S_WAIT;
                end else begin
                    o_wreq  = f_rd(r_p[16:0]);
                    n_ret   = S_C_STEP;
                    n_state = S_WAIT;
                end
            end

            S_C_STEP: begin
                if (rd_mag < MIN_BLOCK) begin
                    n_st    = ST_FAIL;
                    n_state = S_FIN;
                end else begin
                    n_p     = r_p + {1'b0, rd_mag};
                    n_state = S_C_WALK;
                end
            end

            // Block found: check ends here, free goes on to neighbors.
            S_C_TAG: begin
                if (!f_used(r_rd)) begin
                    n_st    = ST_FAIL;
                    n_state = S_FIN;
                end else if (r_op == OP_CHECK) begin
                    n_state = S_FIN;
                end else begin
                    n_s     = rd_mag;
                    n_nb    = r_b + rd_mag;
                    n_pfree = 1'b0;
                    n_nfree = 1'b0;
                    n_state = S_F_PREV;
                end
            end

            S_F_PREV: begin
                if (r_b > FIRST_BLOCK) begin
                    o_wreq  = f_rd(r_b - TAG_BYTES);
                    n_ret   = S_F_GOTP;
                    n_state = S_WAIT;
                end else begin
                    n_state = S_F_NEXT;
                end
            end

            S_F_GOTP: begin
                n_pfree = !f_used(r_rd);
                n_psz   = r_rd[16:0];
                n_state = S_F_NEXT;
            end

            S_F_NEXT: begin
                if (r_nb < r_hs) begin
                    o_wreq  = f_rd(r_nb);
                    n_ret   = S_F_GOTN;
                    n_state = S_WAIT;
                end else begin
                    n_state = S_F_DEC;
                end
            end

            S_F_GOTN: begin
                n_nfree = !f_used(r_rd);
                n_nsz   = r_rd[16:0];
                n_state = S_F_DEC;
            end

            // Pick the merge case.
            S_F_DEC: begin
                n_ua = 1'b0;
                if (r_nfree) begin
                    o_wreq  = f_rd(r_nb + TAG_BYTES);
                    n_ret   = S_F_GOTNX;
                    n_state = S_WAIT;
                end else if (r_pfree) begin
                    n_ba    = r_b - r_psz;
                    n_sa    = r_psz + r_s;
                    n_state = S_WR;
                end else begin
                    o_wreq  = f_rd(LIST_HEAD);
                    n_ret   = S_F_HEAD;
                    n_state = S_WAIT;
                end
            end

            // Search the free list for the link to the next block.
            S_F_GOTNX: begin
                n_nxt   = r_rd;
                n_link  = LIST_HEAD;
                o_wreq  = f_rd(LIST_HEAD);
                n_ret   = S_L_GOT;
                n_state = S_WAIT;
            end

            S_L_GOT: begin
                if (r_rd == 32'd0) begin
                    n_link  = 17'd0;
                    n_state = S_F_LINKED;
                end else if (r_rd == {15'd0, r_nb}) begin
                    n_state = S_F_LINKED;
                end else begin
                    n_link  = r_rd[16:0] + TAG_BYTES;
                    o_wreq  = f_rd(r_rd[16:0] + TAG_BYTES);
                    n_ret   = S_L_GOT;
                    n_state = S_WAIT;
                end
            end

            // Merge with the next block, and with the previous one too when it is free.
            S_F_LINKED: begin
                n_pen = 1'b1;
                n_pa  = r_link;
                if (r_pfree) begin
                    n_pd = r_nxt;
                    n_ba = r_b - r_psz;
                    n_sa = r_psz + r_s + r_nsz;
                end else begin
                    n_pd  = {15'd0, r_b};
                    n_ba  = r_b;
                    n_sa  = r_s + r_nsz;
                    n_qen = 1'b1;
                    n_qa  = r_b + TAG_BYTES;
                    n_qd  = r_nxt;
                end
                n_state = S_WR;
            end

            // Lone block: push at the list head.
            S_F_HEAD: begin
                n_ba    = r_b;
                n_sa    = r_s;
                n_qen   = 1'b1;
                n_qa    = r_b + TAG_BYTES;
                n_qd    = r_rd;
                n_ren   = 1'b1;
                n_ra    = LIST_HEAD;
                n_rdw   = {15'd0, r_b};
                n_state = S_WR;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FMT;
            r_hs    <= CAP;
        end else begin
            r_state <= n_state;
            r_hs    <= n_hs;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_ret   <= n_ret;   r_after <= n_after; r_slot  <= n_slot;
        r_rd    <= n_rd;    r_op    <= n_op;    r_off   <= n_off;
        r_link  <= n_link;  r_cur   <= n_cur;   r_need  <= n_need;  r_fsz <= n_fsz;
        r_nxt   <= n_nxt;   r_b     <= n_b;     r_s     <= n_s;     r_nb  <= n_nb;
        r_psz   <= n_psz;   r_nsz   <= n_nsz;   r_pfree <= n_pfree; r_nfree <= n_nfree;
        r_p     <= n_p;     r_res   <= n_res;   r_st    <= n_st;
        r_pen   <= n_pen;   r_pa    <= n_pa;    r_pd    <= n_pd;
        r_ba    <= n_ba;    r_sa    <= n_sa;    r_ua    <= n_ua;
        r_ben   <= n_ben;   r_bb    <= n_bb;    r_sb    <= n_sb;
        r_qen   <= n_qen;   r_qa    <= n_qa;    r_qd    <= n_qd;
        r_ren   <= n_ren;   r_ra    <= n_ra;    r_rdw   <= n_rdw;
    end

`ifndef SYNTHESIS
    // A format always goes straight on to the tag update program.
    a_fmt_to_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FMT) |=> (r_state == S_WR))
        else $error("format did not start the tag program");

    // A nonzero offset only comes with success.
    a_res_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.result_offset != 16'd0)) |-> (o_rsp.status == ST_OK))
        else $error("result offset with failing status");

    // No new word access while one is in flight.
    a_no_go_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> !o_wreq.go)
        else $error("word access issued while busy");

    // Heap size stays within its range.
    a_hs_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hs >= SIZE_FLOOR) && (r_hs <= CAP))
        else $error("heap size out of range");
`endif

endmodule

// ===== sv/boundary_tag_heap_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Boundary tag heap allocator
// First-fit allocator over an explicit free list with boundary tags.
//
//   channel   signals                        handshake
//   request   i_req (t_in)                   start high while busy low
//   result    o_rsp (t_out)                  o_done high for one cycle
//   config    i_cfg_data (heap size)         i_cfg_we high while busy low
//
// Every heap word access passes the issuing step and then the byte-wide
// store port, one byte at a time. An allocate walks the free list from its
// head and then runs the update, a check walks the blocks from the heap
// start, and a free does the check walk, then searches the free list when
// the next block is free, and runs the merge.
// After reset and after each configuration write a format runs with busy
// high. The receiver cannot stall; each result shows once.
// ----------------------------------------------------------------------------
module boundary_tag_heap_allocator_top
    import bth_pkg::*;
#(
    parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in         i_req,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_data,
    output logic        o_done,
    output t_out        o_rsp
);

    t_word_req wreq;
    t_word_rsp wrsp;
    t_byte_req breq;
    logic [7:0] q;

    // Sequencer.
    bth_ctrl #(.HEAP_BYTES(HEAP_BYTES)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_wreq     (wreq),
        .i_wrsp     (wrsp),
        .o_done     (o_done),
        .o_rsp      (o_rsp)
    );

    // Shared word access unit.
    bth_word u_word (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (wreq),
        .o_rsp   (wrsp),
        .o_breq  (breq),
        .i_q     (q)
    );

    // Heap store.
    bth_mem #(.HEAP_BYTES(HEAP_BYTES)) u_mem (
        .i_clk  (i_clk),
        .i_breq (breq),
        .o_q    (q)
    );

endmodule
